// ===== hw/rtl/nirt_pkg.sv =====
// Package for the NEC-style IR frame transmitter: constants, payload and phase types.
`default_nettype none
package nirt_pkg;

    // Frame geometry, in slots
    localparam int FRAME_SLOTS        = 154;
    localparam int LEADER_MARK_SLOTS  = 16;
    localparam int LEADER_SPACE_SLOTS = 8;

    // Payload bits: 16 customer, 8 command, 8 inverted command
    localparam int CUSTOMER_W = 16;
    localparam int COMMAND_W  = 8;
    localparam int DATA_BITS  = CUSTOMER_W + 2 * COMMAND_W;
    localparam int BIT_CNT_W  = $clog2(DATA_BITS);

    // Slot counter for one frame; leader counter covers up to 32 slots
    localparam int SLOT_IDX_W  = 8;
    localparam int PHASE_CNT_W = 5;

    // Spaces after a data mark
    localparam int ONE_SPACE_SLOTS  = 3;
    localparam int ZERO_SPACE_SLOTS = 1;

    // Item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SEND = 1'b1;

    typedef enum logic [2:0] {
        PH_LEAD_MARK,
        PH_LEAD_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_STOP,
        PH_PAD
    } phase_t;

    typedef struct packed {
        logic                  kind;
        logic [CUSTOMER_W-1:0] customer_code;
        logic [COMMAND_W-1:0]  command_byte;
    } in_item_t;

    typedef struct packed {
        logic carrier_on;
        logic busy_res;
        logic send_refused;
    } out_item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/nirt_frame_seq.sv =====
// Slot sequencer: walks the frame phase by phase, one slot per tick.
`default_nettype none
module nirt_frame_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire nirt_pkg::in_item_t item,
    output nirt_pkg::out_item_t     result
);

    localparam int SLOT_IDX_W  = nirt_pkg::SLOT_IDX_W;
    localparam int PHASE_CNT_W = nirt_pkg::PHASE_CNT_W;
    localparam int BIT_CNT_W   = nirt_pkg::BIT_CNT_W;
    localparam int DATA_BITS   = nirt_pkg::DATA_BITS;

    nirt_pkg::phase_t         phase_reg, phase_next;
    logic [PHASE_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [DATA_BITS-1:0]     data_reg, data_next;
    logic [SLOT_IDX_W-1:0]    slot_idx_reg, slot_idx_next;
    logic                     sending_reg, sending_next;

    logic                     is_send;
    logic                     tick_active;
    logic                     mark_slot;
    logic [PHASE_CNT_W-1:0]   space_last;

    assign is_send     = (item.kind == nirt_pkg::KIND_SEND);
    assign tick_active = step && !is_send && sending_reg;
    assign space_last  = data_reg[DATA_BITS-1]
                       ? PHASE_CNT_W'(nirt_pkg::ONE_SPACE_SLOTS - 1)
                       : PHASE_CNT_W'(nirt_pkg::ZERO_SPACE_SLOTS - 1);

    // Next state
    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        data_next     = data_reg;
        slot_idx_next = slot_idx_reg;
        sending_next  = sending_reg;

        if (step && is_send && !sending_reg)
        begin
            phase_next    = nirt_pkg::PH_LEAD_MARK;
            cnt_next      = '0;
            bit_cnt_next  = '0;
            data_next     = {item.customer_code, item.command_byte, ~item.command_byte};
            slot_idx_next = '0;
            sending_next  = 1'b1;
        end
        else if (tick_active)
        begin
            unique case (phase_reg)
                nirt_pkg::PH_LEAD_MARK:
                begin
                    if (cnt_reg == PHASE_CNT_W'(nirt_pkg::LEADER_MARK_SLOTS - 1))
                    begin
                        phase_next = nirt_pkg::PH_LEAD_SPACE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                nirt_pkg::PH_LEAD_SPACE:
                begin
                    if (cnt_reg == PHASE_CNT_W'(nirt_pkg::LEADER_SPACE_SLOTS - 1))
                    begin
                        phase_next = nirt_pkg::PH_BIT_MARK;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                nirt_pkg::PH_BIT_MARK:
                begin
                    phase_next = nirt_pkg::PH_BIT_SPACE;
                    cnt_next   = '0;
                end
                nirt_pkg::PH_BIT_SPACE:
                begin
                    if (cnt_reg == space_last)
                    begin
                        cnt_next     = '0;
                        data_next    = {data_reg[DATA_BITS-2:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg + 1'b1;
                        if (bit_cnt_reg == BIT_CNT_W'(DATA_BITS - 1))
                            phase_next = nirt_pkg::PH_STOP;
                        else
                            phase_next = nirt_pkg::PH_BIT_MARK;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                nirt_pkg::PH_STOP:
                begin
                    phase_next = nirt_pkg::PH_PAD;
                end
                nirt_pkg::PH_PAD:
                begin
                    phase_next = nirt_pkg::PH_PAD;
                end
                default:
                begin
                    phase_next = nirt_pkg::PH_PAD;
                end
            endcase

            // Frame length is fixed; slots past the end are dropped
            if (slot_idx_reg == SLOT_IDX_W'(nirt_pkg::FRAME_SLOTS - 1))
            begin
                slot_idx_next = '0;
                sending_next  = 1'b0;
            end
            else
            begin
                slot_idx_next = slot_idx_reg + 1'b1;
            end
        end
    end

    // Outputs
    always_comb
    begin
        unique case (phase_reg) inside
            nirt_pkg::PH_LEAD_MARK,
            nirt_pkg::PH_BIT_MARK,
            nirt_pkg::PH_STOP:       mark_slot = 1'b1;
            nirt_pkg::PH_LEAD_SPACE,
            nirt_pkg::PH_BIT_SPACE,
            nirt_pkg::PH_PAD:        mark_slot = 1'b0;
            default:                 mark_slot = 1'b0;
        endcase

        result.carrier_on   = tick_active && mark_slot;
        result.busy_res     = sending_next;
        result.send_refused = is_send && sending_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= nirt_pkg::PH_PAD;
            cnt_reg      <= '0;
            bit_cnt_reg  <= '0;
            slot_idx_reg <= '0;
            sending_reg  <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
            slot_idx_reg <= slot_idx_next;
            sending_reg  <= sending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/nec_ir_frame_transmitter.sv =====
// Top level of the NEC-style IR frame transmitter: handshake and result register.
// A result is registered and presented the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless out_ready stalls; the slot sequencer
// updates on accept; the single output register refills whenever its content is taken.
// Reset (rst_n, async, active low): sequencer idle, slot index 0, no result pending.
`default_nettype none
module nec_ir_frame_transmitter (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire nirt_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output nirt_pkg::out_item_t      out_data
);

    logic                 accept;
    logic                 out_valid_reg, out_valid_next;
    nirt_pkg::out_item_t  out_data_reg;
    nirt_pkg::out_item_t  seq_result;

    // The output register is free when empty or being drained this cycle,
    // so a new transaction can enter every cycle while the sink keeps up.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Sequencer state moves only on an accepted transaction; its result
    // is computed combinationally from the current state and the item.
    nirt_frame_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept),
        .item   (in_data),
        .result (seq_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Payload holds while a result waits to be taken
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= seq_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ===== test/nec_ir_frame_transmitter_tb.sv =====
// Self-checking testbench for the NEC IR frame transmitter: slot playback, refusals, handshakes.
`default_nettype none
module nec_ir_frame_transmitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nirt_pkg::*;

    // Slot-level model of the transmitter plus the queue of results it has promised.
    class ir_frame_scoreboard;
        bit [FRAME_SLOTS-1:0] slot_bits;
        int unsigned          slot_pos;
        bit                   playing;
        out_item_t            due_q[$];
        int                   errors;

        function new();
            slot_bits = '0;
            slot_pos  = 0;
            playing   = 1'b0;
            errors    = 0;
        endfunction

        // Lay out leader, 32 data bits MSB first, stop mark, then pad with spaces.
        function void load_frame(logic [CUSTOMER_W-1:0] cust, logic [COMMAND_W-1:0] cmd);
            bit               seq[$];
            logic [DATA_BITS-1:0] payload;
            payload = {cust, cmd, ~cmd};
            repeat (LEADER_MARK_SLOTS) seq.push_back(1'b1);
            repeat (LEADER_SPACE_SLOTS) seq.push_back(1'b0);
            for (int b = DATA_BITS - 1; b >= 0; b--)
            begin
                seq.push_back(1'b1);
                repeat (payload[b] ? ONE_SPACE_SLOTS : ZERO_SPACE_SLOTS) seq.push_back(1'b0);
            end
            seq.push_back(1'b1);
            slot_bits = '0;
            for (int s = 0; s < FRAME_SLOTS && s < seq.size(); s++)
                slot_bits[s] = seq[s];
        endfunction

        // One accepted input transaction produces exactly one expected result.
        function void note_input(in_item_t it);
            out_item_t r;
            r = '0;
            if (it.kind == KIND_SEND)
            begin
                if (playing)
                    r.send_refused = 1'b1;
                else
                begin
                    load_frame(it.customer_code, it.command_byte);
                    slot_pos = 0;
                    playing  = 1'b1;
                end
            end
            else if (playing)
            begin
                r.carrier_on = slot_bits[slot_pos];
                slot_pos++;
                if (slot_pos >= FRAME_SLOTS)
                begin
                    slot_pos = 0;
                    playing  = 1'b0;
                end
            end
            r.busy_res = playing;
            due_q.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (due_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                return;
            end
            want = due_q.pop_front();
            if (got.carrier_on !== want.carrier_on)
            begin
                errors++;
                $display("%0t: carrier_on expected %0b actual %0b",
                         $time, want.carrier_on, got.carrier_on);
            end
            if (got.busy_res !== want.busy_res)
            begin
                errors++;
                $display("%0t: busy_res expected %0b actual %0b",
                         $time, want.busy_res, got.busy_res);
            end
            if (got.send_refused !== want.send_refused)
            begin
                errors++;
                $display("%0t: send_refused expected %0b actual %0b",
                         $time, want.send_refused, got.send_refused);
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    ir_frame_scoreboard sb;
    bit                 no_idle;     // when set, both sides run back to back
    int                 items_sent;

    nec_ir_frame_transmitter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Random idle gap before the next transaction on either side; skipped in back-to-back stretches.
    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic in_item_t rand_item(logic kind);
        in_item_t it;
        it.kind          = kind;
        it.customer_code = CUSTOMER_W'($urandom_range(0, 16'hFFFF));
        it.command_byte  = COMMAND_W'($urandom_range(0, 8'hFF));
        return it;
    endfunction

    // Offer one input transaction and hold it until taken. valid is only dropped
    // when a gap follows, so a back-to-back item never sees low and high in one step.
    task automatic drive_item(input in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic send_frame(input logic [CUSTOMER_W-1:0] cust, input logic [COMMAND_W-1:0] cmd);
        in_item_t it;
        it = rand_item(KIND_SEND);
        it.customer_code = cust;
        it.command_byte  = cmd;
        drive_item(it);
    endtask

    // Tick the whole frame out; refused_odds > 0 sprinkles send requests into the
    // busy window, which the block must reject without disturbing playback.
    task automatic play_frame(input int refused_odds);
        int slots_left;
        slots_left = FRAME_SLOTS;
        while (slots_left > 0)
        begin
            if (refused_odds > 0 && $urandom_range(0, refused_odds - 1) == 0)
                drive_item(rand_item(KIND_SEND));
            else
            begin
                drive_item(rand_item(KIND_TICK));
                slots_left--;
            end
        end
    endtask

    // Called right after a transaction was taken: withdraw valid so the
    // last item is not offered again while waiting.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Result side: every accepted output transaction is checked at the edge it is taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Receiver: random stall per result, with the same back-to-back stretches.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Stimulus and end of run
    initial
    begin
        sb         = new();
        no_idle    = 1'b0;
        items_sent = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick while idle, all-ones frame with a refused send right away,
        // all-zero frame sent the moment the previous one ends, then the 0001/01 and 8000/80 frames.
        drive_item(rand_item(KIND_TICK));
        send_frame(16'hFFFF, 8'hFF);
        send_frame(16'h0000, 8'h00);
        play_frame(0);
        send_frame(16'h0000, 8'h00);
        play_frame(0);
        drive_item(rand_item(KIND_TICK));
        send_frame(16'h0001, 8'h01);
        play_frame(40);
        send_frame(16'h8000, 8'h80);
        play_frame(0);

        // Hold the sender until the result path has fully drained once.
        wait_drained();

        // Random: mostly complete frames with random codes, some noise in between.
        while (items_sent < 1650)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 12))
                    drive_item(rand_item(1'($urandom_range(0, 1))));
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    drive_item(rand_item(KIND_TICK));
                drive_item(rand_item(KIND_SEND));
                play_frame($urandom_range(0, 1) ? 25 : 0);
            end
        end

        // Let any frame started by noise run out so nothing is left mid-frame.
        play_frame(0);
        no_idle = 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
